// ----- rtl/infix_to_postfix_operator_stack_macros.svh -----
// assertion macros for the infix to postfix operator stack
// used by the checker bound to the top level
`ifndef INFIX_TO_POSTFIX_OPERATOR_STACK_MACROS_SVH
`define INFIX_TO_POSTFIX_OPERATOR_STACK_MACROS_SVH

// same-cycle implication
`define ITP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("itp assertion failed");

// next-cycle implication
`define ITP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("itp assertion failed");

`endif

// ----- rtl/itp_pkg.sv -----
// shared types, constants and precedence function for the operator stack
// no dependencies
package itp_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	localparam int FQ_DEPTH = 2;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_OPERAND  = 2'd0,
		CMD_OPERATOR = 2'd1,
		CMD_END      = 2'd2
	} cmd_e;

	localparam logic [1:0] KIND_OPERAND  = 2'd0;
	localparam logic [1:0] KIND_OPERATOR = 2'd1;
	localparam logic [1:0] KIND_PRINT    = 2'd2;

	typedef logic [1:0] cls_t;
	localparam cls_t CLS_OTHER = 2'd0;
	localparam cls_t CLS_ADD   = 2'd1;
	localparam cls_t CLS_MUL   = 2'd2;

	localparam logic [7:0] CH_MUL = 8'h2A;
	localparam logic [7:0] CH_DIV = 8'h2F;
	localparam logic [7:0] CH_ADD = 8'h2B;
	localparam logic [7:0] CH_SUB = 8'h2D;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] operand_value;
		logic [7:0]  operator_code;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [31:0] out_operand;
		logic [7:0]  out_operator;
		logic        overflow_seen;
		logic        last;
	} out_item_t;

	typedef struct packed {
		cmd_e        kind;
		logic [31:0] value;
		logic [7:0]  code;
		cls_t        cls;
	} tok_t;

	typedef struct packed {
		logic [7:0] code;
		cls_t       below_cls;
	} entry_t;

	function automatic cls_t prec_class(input logic [7:0] code);
		cls_t c;
		c = CLS_OTHER;
		if (code == CH_MUL || code == CH_DIV) begin
			c = CLS_MUL;
		end else if (code == CH_ADD || code == CH_SUB) begin
			c = CLS_ADD;
		end
		return c;
	endfunction

endpackage

// ----- rtl/infix_to_postfix_operator_stack.sv -----
// operand: current-token register, then result register; operator: one pop per cycle, push folded in
// end: pops each stacked operator in turn, then emits the print marker
// the back end takes a new token only once done with the last, and pops happen only while the result
// register is free; a 2-entry queue separates front and back
// arst_n clears the queue, current-token valid, stack count, overflow flag and result valid; stack data is not reset
// top level: front, token queue and back end; depends on itp_pkg
module infix_to_postfix_operator_stack (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  itp_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output itp_pkg::out_item_t result
);

	logic          fq_push_valid;
	logic          fq_push_ready;
	itp_pkg::tok_t fq_push_tok;
	logic          fq_pop_valid;
	logic          fq_pop_ready;
	itp_pkg::tok_t fq_pop_tok;

	itp_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (fq_push_valid),
		.push_ready (fq_push_ready),
		.push_tok   (fq_push_tok)
	);

	itp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_push_valid),
		.push_ready (fq_push_ready),
		.push_tok   (fq_push_tok),
		.pop_valid  (fq_pop_valid),
		.pop_ready  (fq_pop_ready),
		.pop_tok    (fq_pop_tok)
	);

	itp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid    (fq_pop_valid),
		.tok_ready    (fq_pop_ready),
		.tok          (fq_pop_tok),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- rtl/itp_front.sv -----
// front end: accepts tokens, drops unused commands, tags operator precedence
// depends on itp_pkg
module itp_front (
	input  logic             item_valid,
	output logic             item_ready,
	input  itp_pkg::in_item_t item,
	output logic             push_valid,
	input  logic             push_ready,
	output itp_pkg::tok_t    push_tok
);

	always_comb begin
		item_ready = push_ready;
		push_valid = 1'b0;
		push_tok.kind = itp_pkg::CMD_OPERAND;
		push_tok.value = item.operand_value;
		push_tok.code = item.operator_code;
		push_tok.cls = itp_pkg::prec_class(item.operator_code);
		case (item.command)
			itp_pkg::CMD_OPERAND: begin
				push_valid = item_valid;
				push_tok.kind = itp_pkg::CMD_OPERAND;
			end
			itp_pkg::CMD_OPERATOR: begin
				push_valid = item_valid;
				push_tok.kind = itp_pkg::CMD_OPERATOR;
			end
			itp_pkg::CMD_END: begin
				push_valid = item_valid;
				push_tok.kind = itp_pkg::CMD_END;
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/itp_fifo.sv -----
// short token queue between front and back
// depends on itp_pkg
module itp_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  itp_pkg::tok_t push_tok,
	output logic          pop_valid,
	input  logic          pop_ready,
	output itp_pkg::tok_t pop_tok
);

	itp_pkg::tok_t                mem_q [itp_pkg::FQ_DEPTH];
	logic [itp_pkg::FQ_PTR_W-1:0] wr_ptr_q;
	logic [itp_pkg::FQ_PTR_W-1:0] rd_ptr_q;
	logic [itp_pkg::FQ_CNT_W-1:0] cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign push_ready = cnt_q != itp_pkg::FQ_CNT_W'(itp_pkg::FQ_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_tok = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	function automatic logic [itp_pkg::FQ_PTR_W-1:0] ptr_next(
		input logic [itp_pkg::FQ_PTR_W-1:0] p
	);
		logic [itp_pkg::FQ_PTR_W-1:0] n;
		n = p + itp_pkg::FQ_PTR_W'(1);
		if (p == itp_pkg::FQ_PTR_W'(itp_pkg::FQ_DEPTH - 1)) begin
			n = '0;
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + itp_pkg::FQ_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - itp_pkg::FQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

// ----- rtl/itp_back.sv -----
// back end: operator stack, pops, pushes and the result register
// depends on itp_pkg
module itp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tok_valid,
	output logic                tok_ready,
	input  itp_pkg::tok_t       tok,
	output logic                result_valid,
	input  logic                result_ready,
	output itp_pkg::out_item_t  result
);

	itp_pkg::tok_t              cur_q;
	logic                       cur_valid_q;
	itp_pkg::entry_t            stack_q [itp_pkg::STACK_DEPTH];
	logic [itp_pkg::CNT_W-1:0]  count_q;
	logic                       ovf_q;
	logic                       out_valid_q;
	itp_pkg::out_item_t         out_q;

	logic [itp_pkg::CNT_W-1:0]  top_sum;
	logic [itp_pkg::IDX_W-1:0]  top_idx;
	itp_pkg::entry_t            top;
	itp_pkg::cls_t              top_cls;
	logic                       nonempty;
	logic                       full;
	logic                       pop_hit;
	logic                       more;
	logic                       out_free;
	logic                       emit;
	itp_pkg::out_item_t         emit_item;
	logic                       done;
	logic                       wr_en;
	logic [itp_pkg::IDX_W-1:0]  wr_idx;
	itp_pkg::entry_t            wr_entry;
	logic [itp_pkg::CNT_W-1:0]  count_d;
	logic                       ovf_d;

	assign tok_ready = !cur_valid_q;
	assign result_valid = out_valid_q;
	assign result = out_q;

	always_comb begin
		top_sum = count_q - itp_pkg::CNT_W'(1);
		top_idx = top_sum[itp_pkg::IDX_W-1:0];
		top = stack_q[top_idx];
		top_cls = itp_pkg::prec_class(top.code);
		nonempty = count_q != '0;
		full = count_q == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH);
		pop_hit = nonempty && (top_cls >= cur_q.cls);
		more = (count_q > itp_pkg::CNT_W'(1)) && (top.below_cls >= cur_q.cls);
		out_free = !out_valid_q || result_ready;

		emit = 1'b0;
		emit_item = '0;
		done = 1'b0;
		wr_en = 1'b0;
		wr_idx = top_idx;
		wr_entry.code = cur_q.code;
		wr_entry.below_cls = top.below_cls;
		count_d = count_q;
		ovf_d = ovf_q;

		if (cur_valid_q) begin
			case (cur_q.kind)
				itp_pkg::CMD_OPERAND: begin
					if (out_free) begin
						emit = 1'b1;
						emit_item.out_kind = itp_pkg::KIND_OPERAND;
						emit_item.out_operand = cur_q.value;
						emit_item.last = 1'b1;
						done = 1'b1;
					end
				end
				itp_pkg::CMD_OPERATOR: begin
					if (pop_hit) begin
						if (out_free) begin
							emit = 1'b1;
							emit_item.out_kind = itp_pkg::KIND_OPERATOR;
							emit_item.out_operator = top.code;
							emit_item.last = !more;
							if (more) begin
								count_d = top_sum;
							end else begin
								// last pop: new operator takes the freed slot
								wr_en = 1'b1;
								wr_idx = top_idx;
								wr_entry.below_cls = top.below_cls;
								done = 1'b1;
							end
						end
					end else begin
						if (!full) begin
							wr_en = 1'b1;
							wr_idx = count_q[itp_pkg::IDX_W-1:0];
							wr_entry.below_cls = top_cls;
							count_d = count_q + itp_pkg::CNT_W'(1);
						end else begin
							ovf_d = 1'b1;
						end
						done = 1'b1;
					end
				end
				itp_pkg::CMD_END: begin
					if (out_free) begin
						emit = 1'b1;
						if (nonempty) begin
							emit_item.out_kind = itp_pkg::KIND_OPERATOR;
							emit_item.out_operator = top.code;
							count_d = top_sum;
						end else begin
							emit_item.out_kind = itp_pkg::KIND_PRINT;
							emit_item.overflow_seen = ovf_q;
							emit_item.last = 1'b1;
							done = 1'b1;
						end
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			count_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			ovf_q <= ovf_d;
			if (tok_valid && tok_ready) begin
				cur_valid_q <= 1'b1;
			end else if (done) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_valid && tok_ready) begin
			cur_q <= tok;
		end
		if (emit) begin
			out_q <= emit_item;
		end
		if (wr_en) begin
			stack_q[wr_idx] <= wr_entry;
		end
	end

endmodule

// ----- rtl/itp_checker.sv -----
// port-level checks for the operator stack, bound to the top level
// depends on itp_pkg and infix_to_postfix_operator_stack_macros.svh
`include "infix_to_postfix_operator_stack_macros.svh"

module itp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input itp_pkg::in_item_t  item,
	input logic               result_valid,
	input logic               result_ready,
	input itp_pkg::out_item_t result
);

	logic item_stall;
	logic res_stall;
	logic res_operand;
	logic res_print;
	logic res_operator;
	logic ok_operand;
	logic ok_print;
	logic ok_operator;

	assign item_stall = item_valid && !item_ready;
	assign res_stall = result_valid && !result_ready;
	assign res_operand = result_valid && result.out_kind == itp_pkg::KIND_OPERAND;
	assign res_print = result_valid && result.out_kind == itp_pkg::KIND_PRINT;
	assign res_operator = result_valid && result.out_kind == itp_pkg::KIND_OPERATOR;
	assign ok_operand = result.last && result.out_operator == 8'd0 && !result.overflow_seen;
	assign ok_print = result.last && result.out_operand == 32'd0 && result.out_operator == 8'd0;
	assign ok_operator = result.out_operand == 32'd0 && !result.overflow_seen;

	`ITP_ASSERT_NEXT(a_item_hold, clk, arst_n, item_stall, item_valid && $stable(item))
	`ITP_ASSERT_NEXT(a_result_hold, clk, arst_n, res_stall, result_valid && $stable(result))
	`ITP_ASSERT_IMPLY(a_operand_single, clk, arst_n, res_operand, ok_operand)
	`ITP_ASSERT_IMPLY(a_print_last, clk, arst_n, res_print, ok_print)
	`ITP_ASSERT_IMPLY(a_operator_clean, clk, arst_n, res_operator, ok_operator)

endmodule

bind infix_to_postfix_operator_stack itp_checker u_itp_checker (.*);
